>>> hdl/kmp_prefix_table_builder_assert.svh
// assertion macros for the kmp prefix table builder
// used by modules that sit in a clk / rst_n (active low) domain
`ifndef KMP_PREFIX_TABLE_BUILDER_ASSERT_SVH
`define KMP_PREFIX_TABLE_BUILDER_ASSERT_SVH

// same-cycle implication
`define KMP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmp assertion failed");

// next-cycle implication
`define KMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmp assertion failed");

`endif

>>> hdl/kmp_pkg.sv
// shared constants and memory request types for the kmp prefix table builder
// no dependencies
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int POS_W       = $clog2(MAX_PATTERN + 1);
  localparam int SYM_W       = 8;
  localparam int OUT_LEN_W   = 8;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SYM_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } pat_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } pre_req_t;

endpackage

>>> hdl/kmp_in_if.sv
// input channel: pattern byte and start flag with valid / ready
// depends on kmp_pkg
`timescale 1ns / 1ps

interface kmp_in_if;
  logic                      valid;
  logic                      ready;
  logic [kmp_pkg::SYM_W-1:0] symbol;
  logic                      start_new;

  modport source (output valid, output symbol, output start_new, input ready);
  modport sink   (input valid, input symbol, input start_new, output ready);
endinterface

>>> hdl/kmp_out_if.sv
// result channel: prefix length and overflow flag with valid / ready
// depends on kmp_pkg
`timescale 1ns / 1ps

interface kmp_out_if;
  logic                          valid;
  logic                          ready;
  logic [kmp_pkg::OUT_LEN_W-1:0] prefix_length;
  logic                          overflow;

  modport source (output valid, output prefix_length, output overflow, input ready);
  modport sink   (input valid, input prefix_length, input overflow, output ready);
endinterface

>>> hdl/kmp_prefix_table_builder.sv
// top level of the kmp prefix table builder: sequencer plus pattern and failure stores
// depends on kmp_pkg, kmp_in_if, kmp_out_if, kmp_ram and kmp_ctrl
//
//   channel   dir   payload                    handshake
//   in_chan   in    symbol, start_new          valid / ready
//   out_chan  out   prefix_length, overflow    valid / ready
//
// one request in flight; the first byte of a pattern and an overflow byte finish without a read
// other bytes take one pattern-store read and compare, plus per fallback step one failure-store read,
// then one pattern-store read and compare; fallback steps amortize to about 2 reads per byte
// synchronous active-low reset clears the sequencer, position, match length and output valid only
// a result waiting on out_chan does not block a new request; a stalled output holds
// the finished result in the sequencer until the output register frees
`timescale 1ns / 1ps

module kmp_prefix_table_builder (
  input  logic      clk,
  input  logic      rst_n,
  kmp_in_if.sink    in_chan,
  kmp_out_if.source out_chan
);
  import kmp_pkg::*;

  pat_req_t          pat_req;
  pre_req_t          pre_req;
  logic [SYM_W-1:0]  pat_rdata;
  logic [ADDR_W-1:0] pre_rdata;

  kmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .pat_req   (pat_req),
    .pat_rdata (pat_rdata),
    .pre_req   (pre_req),
    .pre_rdata (pre_rdata)
  );

  // pattern bytes
  kmp_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (SYM_W)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_req.we),
    .waddr (pat_req.waddr),
    .wdata (pat_req.wdata),
    .re    (pat_req.re),
    .raddr (pat_req.raddr),
    .rdata (pat_rdata)
  );

  // failure values
  kmp_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (ADDR_W)
  ) u_pre_ram (
    .clk   (clk),
    .we    (pre_req.we),
    .waddr (pre_req.waddr),
    .wdata (pre_req.wdata),
    .re    (pre_req.re),
    .raddr (pre_req.raddr),
    .rdata (pre_rdata)
  );

endmodule

>>> hdl/kmp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module kmp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/kmp_ctrl.sv
// sequencer and shared compare unit of the kmp prefix table builder
// depends on kmp_pkg, kmp_in_if, kmp_out_if and the assertion header
`timescale 1ns / 1ps

module kmp_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  kmp_in_if.sink                     in_chan,
  kmp_out_if.source                  out_chan,
  output kmp_pkg::pat_req_t          pat_req,
  input  logic [kmp_pkg::SYM_W-1:0]  pat_rdata,
  output kmp_pkg::pre_req_t          pre_req,
  input  logic [kmp_pkg::ADDR_W-1:0] pre_rdata
);
  import kmp_pkg::*;

  `include "kmp_prefix_table_builder_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FALL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  function automatic logic [OUT_LEN_W-1:0] to_out_len(input logic [ADDR_W-1:0] l);
    logic [ADDR_W+OUT_LEN_W-1:0] w;
    w = {{OUT_LEN_W{1'b0}}, l};
    return w[OUT_LEN_W-1:0];
  endfunction

  logic [1:0]           state_r, state_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [ADDR_W-1:0]    match_r, match_nxt;
  logic [ADDR_W-1:0]    len_r, len_nxt;
  logic [SYM_W-1:0]     sym_r, sym_nxt;
  logic [ADDR_W-1:0]    res_r, res_nxt;
  logic                 rovf_r, rovf_nxt;
  logic                 out_valid_r;
  logic [OUT_LEN_W-1:0] out_len_r;
  logic                 out_ovf_r;

  logic                 in_fire;
  logic                 out_free;
  logic [POS_W-1:0]     pos_eff;
  logic [POS_W-1:0]     pos_m1;
  logic [ADDR_W-1:0]    match_eff;
  logic [ADDR_W-1:0]    len0;
  logic                 ovf_in;
  logic                 hit;
  logic [ADDR_W-1:0]    fall_len;
  logic [ADDR_W-1:0]    fin_len;

  logic                 done;
  logic [ADDR_W-1:0]    done_len;
  logic                 done_ovf;
  logic [POS_W-1:0]     done_pos;
  logic [SYM_W-1:0]     done_sym;
  logic                 pat_re;
  logic [ADDR_W-1:0]    pat_raddr;
  logic                 pre_re;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // start flag restarts the pattern before this byte is handled
  assign pos_eff   = in_chan.start_new ? '0 : pos_r;
  assign match_eff = in_chan.start_new ? '0 : match_r;
  assign pos_m1    = pos_eff - 1'b1;
  assign len0      = (POS_W'(match_eff) >= pos_eff) ? pos_m1[ADDR_W-1:0] : match_eff;
  assign ovf_in    = (pos_eff >= POS_W'(MAX_PATTERN));

  assign hit      = (pat_rdata == sym_r);
  assign fall_len = (pre_rdata < len_r) ? pre_rdata : '0;
  assign fin_len  = hit ? ADDR_W'(len_r + 1'b1) : '0;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    match_nxt = match_r;
    len_nxt   = len_r;
    sym_nxt   = sym_r;
    res_nxt   = res_r;
    rovf_nxt  = rovf_r;
    done      = 1'b0;
    done_len  = '0;
    done_ovf  = 1'b0;
    done_pos  = pos_r;
    done_sym  = sym_r;
    pat_re    = 1'b0;
    pat_raddr = len_r;
    pre_re    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sym_nxt   = in_chan.symbol;
          pos_nxt   = pos_eff;
          match_nxt = match_eff;
          if (ovf_in || (pos_eff == '0)) begin
            if (out_free) begin
              done     = 1'b1;
              done_ovf = ovf_in;
              done_pos = pos_eff;
              done_sym = in_chan.symbol;
            end else begin
              res_nxt   = '0;
              rovf_nxt  = ovf_in;
              state_nxt = S_DONE;
            end
          end else begin
            pat_re    = 1'b1;
            pat_raddr = len0;
            len_nxt   = len0;
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (hit || (len_r == '0)) begin
          if (out_free) begin
            done      = 1'b1;
            done_len  = fin_len;
            state_nxt = S_IDLE;
          end else begin
            res_nxt   = fin_len;
            rovf_nxt  = 1'b0;
            state_nxt = S_DONE;
          end
        end else begin
          // mismatch: fetch the failure value one below
          pre_re    = 1'b1;
          state_nxt = S_FALL;
        end
      end
      S_FALL: begin
        len_nxt   = fall_len;
        pat_re    = 1'b1;
        pat_raddr = fall_len;
        state_nxt = S_CMP;
      end
      S_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          done_len  = res_r;
          done_ovf  = rovf_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done && !done_ovf) begin
      pos_nxt   = POS_W'(done_pos + 1'b1);
      match_nxt = done_len;
    end
  end

  assign pat_req.we    = done && !done_ovf;
  assign pat_req.waddr = done_pos[ADDR_W-1:0];
  assign pat_req.wdata = done_sym;
  assign pat_req.re    = pat_re;
  assign pat_req.raddr = pat_raddr;

  assign pre_req.we    = done && !done_ovf;
  assign pre_req.waddr = done_pos[ADDR_W-1:0];
  assign pre_req.wdata = done_len;
  assign pre_req.re    = pre_re;
  assign pre_req.raddr = ADDR_W'(len_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      match_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    sym_r  <= sym_nxt;
    res_r  <= res_nxt;
    rovf_r <= rovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_len_r <= to_out_len(done_len);
      out_ovf_r <= done_ovf;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.prefix_length = out_len_r;
  assign out_chan.overflow      = out_ovf_r;

  `KMP_ASSERT_NEXT(a_fall_to_cmp, state_r == S_FALL, state_r == S_CMP)
  `KMP_ASSERT_IMPL(a_match_below_pos, pos_r != '0, POS_W'(match_r) < pos_r)
  `KMP_ASSERT_IMPL(a_write_not_read, pat_req.we, !pat_req.re && !pre_req.re)
  `KMP_ASSERT_IMPL(a_ovf_zero_len, out_valid_r && out_ovf_r, out_len_r == '0)

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for kmp_prefix_table_builder: random failure-function patterns with an in-house predictor
// depends on kmp_pkg, kmp_in_if, kmp_out_if and the kmp_prefix_table_builder rtl

module tb_top;
  import kmp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEMS_TARGET = 450;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] prefix_length;
    logic                 overflow;
  } kmp_result_t;

  // tracks the pattern the block has seen and the failure value each request should return
  class prefix_scoreboard;
    logic [SYM_W-1:0] pattern_bytes [MAX_PATTERN];
    int unsigned      failure_values [MAX_PATTERN];
    int unsigned      match_len;
    int unsigned      pos;
    kmp_result_t      pending_results [$];
    int unsigned      errors;

    function new();
      match_len = 0;
      pos       = 0;
      errors    = 0;
    endfunction

    function void note_request(logic [SYM_W-1:0] sym, logic start);
      kmp_result_t res;
      int unsigned len;
      if (start) begin
        pos       = 0;
        match_len = 0;
      end
      if (pos >= MAX_PATTERN) begin
        // store full: byte dropped, nothing changes
        res.prefix_length = '0;
        res.overflow      = 1'b1;
      end else begin
        len = 0;
        if (pos != 0) begin
          len = match_len;
          if (len >= pos) len = pos - 1;
          while (len > 0 && pattern_bytes[len] != sym) begin
            len = (failure_values[len-1] < len) ? failure_values[len-1] : 0;
          end
          if (pattern_bytes[len] == sym) len++;
        end
        pattern_bytes[pos]  = sym;
        failure_values[pos] = len;
        match_len           = len;
        pos++;
        res.prefix_length = OUT_LEN_W'(len);
        res.overflow      = 1'b0;
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_LEN_W-1:0] plen, logic ovf);
      kmp_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("unexpected result: prefix_length %0d overflow %0b", plen, ovf);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (plen !== exp_res.prefix_length) begin
        $error("prefix_length mismatch: expected %0d actual %0d", exp_res.prefix_length, plen);
        errors++;
      end
      if (ovf !== exp_res.overflow) begin
        $error("overflow mismatch: expected %0b actual %0b", exp_res.overflow, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  kmp_in_if  in_chan ();
  kmp_out_if out_chan ();

  kmp_prefix_table_builder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  prefix_scoreboard sb;
  int unsigned      items_sent;
  int unsigned      send_burst;
  int unsigned      cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // source side idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) send_burst = $urandom_range(10, 30);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(logic [SYM_W-1:0] sym, logic start);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.symbol    <= sym;
    in_chan.start_new <= start;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(sym, start);
    items_sent++;
  endtask

  // short pattern over a small alphabet so prefixes repeat; some are pure noise
  task automatic send_short_pattern();
    logic [SYM_W-1:0] alpha [3];
    logic [SYM_W-1:0] sym;
    int unsigned      n_sym;
    int unsigned      len;
    bit               noise;
    logic             start;
    n_sym = $urandom_range(1, 3);
    foreach (alpha[i]) alpha[i] = SYM_W'($urandom);
    len   = $urandom_range(1, 24);
    noise = ($urandom_range(0, 6) == 0);
    for (int i = 0; i < len; i++) begin
      sym = noise ? SYM_W'($urandom) : alpha[$urandom_range(0, n_sym - 1)];
      if (i == 0) start = ($urandom_range(0, 9) != 0);
      else start = ($urandom_range(0, 40) == 0);
      send_byte(sym, start);
    end
  endtask

  // fills the whole store with a periodic pattern, then runs past the end
  task automatic send_full_pattern();
    logic [SYM_W-1:0] period_bytes [5];
    logic [SYM_W-1:0] pair [2];
    logic [SYM_W-1:0] sym;
    int unsigned      period;
    period  = $urandom_range(1, 5);
    pair[0] = SYM_W'($urandom);
    pair[1] = SYM_W'($urandom);
    foreach (period_bytes[i]) period_bytes[i] = pair[$urandom_range(0, 1)];
    for (int i = 0; i < MAX_PATTERN; i++) begin
      sym = period_bytes[i % period];
      // rare break in the period forces a deep fallback
      if ($urandom_range(0, 59) == 0) sym = SYM_W'($urandom);
      send_byte(sym, i == 0);
    end
    for (int i = 0; i < 4; i++) send_byte(SYM_W'($urandom), 1'b0);
  endtask

  // result side: random stalls, one long hold-off so the block backs up
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned hold_left;
    int unsigned results_seen;
    bit          hold_done;
    int unsigned r;
    stall_left   = 0;
    free_left    = 0;
    hold_left    = 0;
    results_seen = 0;
    hold_done    = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_chan.valid && out_chan.ready) begin
          sb.check_result(out_chan.prefix_length, out_chan.overflow);
          results_seen++;
        end
        if (!hold_done && results_seen >= 150) begin
          hold_done = 1;
          hold_left = 200;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_chan.ready <= 1'b0;
        end else if (stall_left > 0) begin
          stall_left--;
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= 1'b1;
          if (free_left > 0) begin
            free_left--;
          end else begin
            r = $urandom_range(0, 99);
            if (r < 3) free_left = $urandom_range(20, 40);
            else if (r < 25) stall_left = $urandom_range(1, 3);
            else if (r < 29) stall_left = $urandom_range(8, 30);
          end
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    sb         = new();
    items_sent = 0;
    send_burst = 0;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.symbol    <= '0;
    in_chan.start_new <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first pattern after reset without a start flag
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // alternating bytes, then a break that falls back through the table
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    // all-ones run
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // single-byte patterns
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b1);

    while (items_sent < 180) send_short_pattern();
    send_full_pattern();
    while (items_sent < ITEMS_TARGET) send_short_pattern();
    in_chan.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
